FILE: hdl/spfc_pkg.sv
// spfc_pkg: shared types, constants and helpers for the serial port rx fifo controller
// no dependencies; imported by spfc_rx_fifo, spfc_res_queue and the core top level
package spfc_pkg;

    // rx fifo sizing
    localparam int RX_DEPTH = 8;
    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int RX_SUM_W = RX_CNT_W + 1;
    // irq level compare width, levels go up to 8
    localparam int LVL_W    = (RX_CNT_W > 4) ? RX_CNT_W : 4;

    // result queue sizing
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // request codes
    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_DWRITE = 3'd1;
    localparam logic [2:0] REQ_DREAD  = 3'd2;
    localparam logic [2:0] REQ_CWRITE = 3'd3;
    localparam logic [2:0] REQ_STATUS = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_BAUD_FACTOR = 2'd0;
    localparam logic [1:0] CFG_CHAR_LEN    = 2'd1;
    localparam logic [1:0] CFG_BAUD_RELOAD = 2'd2;

    // configuration reset values
    localparam logic [1:0]  FACTOR_RST = 2'd1;
    localparam logic [1:0]  LEN_RST    = 2'd3;
    localparam logic [15:0] RELOAD_RST = 16'h0088;

    // control word bit positions
    localparam int CW_TXEN  = 0;
    localparam int CW_DTR   = 1;
    localparam int CW_ACK   = 4;
    localparam int CW_SRST  = 6;
    localparam int CW_LVL_L = 8;
    localparam int CW_RXIE  = 11;
    localparam int CW_SLOT  = 13;

    localparam logic [7:0] BYTE_NONE = 8'hFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] wdata;
        logic [7:0]  resp_byte;
        logic        resp_valid;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic [9:0] status;
        logic       irq_line;
        logic       periph_reset;
        logic       slot_sel;
        logic       xfer_done;
    } t_out;

    // command group from the control logic to the rx fifo
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] data;
    } t_fifo_cmd;

    // baud factor as a shift: x1, x1, x16, x64
    function automatic logic [2:0] factor_shift(input logic [1:0] sel);
        logic [2:0] sh;
        case (sel)
            2'd2:    sh = 3'd4;
            2'd3:    sh = 3'd6;
            default: sh = 3'd0;
        endcase
        return sh;
    endfunction

    // rx irq fill level: 1, 2, 4 or 8 bytes
    function automatic logic [LVL_W-1:0] irq_level(input logic [1:0] sel);
        logic [LVL_W-1:0] lv;
        case (sel)
            2'd0:    lv = LVL_W'(1);
            2'd1:    lv = LVL_W'(2);
            2'd2:    lv = LVL_W'(4);
            default: lv = LVL_W'(8);
        endcase
        return lv;
    endfunction

endpackage

FILE: hdl/spfc_rx_fifo.sv
// spfc_rx_fifo: circular rx byte store with fill count, overwrite of last entry when full
// depends on spfc_pkg (sizing constants, t_fifo_cmd)
module spfc_rx_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spfc_pkg::t_fifo_cmd          i_cmd,
    output logic [spfc_pkg::RX_CNT_W-1:0] o_count,
    output logic [7:0]                   o_rd_data
);
    import spfc_pkg::*;

    logic [7:0]          mem [RX_DEPTH];
    logic [RX_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [RX_CNT_W-1:0] r_count, n_count;
    logic [7:0]          r_rd_data;
    logic                full;
    logic [RX_CNT_W-1:0] wr_off;
    logic [RX_SUM_W-1:0] wr_sum;
    logic [RX_PTR_W-1:0] wr_addr;

    assign full   = (r_count == RX_CNT_W'(RX_DEPTH));
    // full: overwrite the newest entry
    assign wr_off = full ? RX_CNT_W'(RX_DEPTH - 1) : r_count;
    assign wr_sum = RX_SUM_W'(r_rd_ptr) + RX_SUM_W'(wr_off);

    always_comb begin
        if (wr_sum >= RX_SUM_W'(RX_DEPTH)) begin
            wr_addr = RX_PTR_W'(wr_sum - RX_SUM_W'(RX_DEPTH));
        end else begin
            wr_addr = RX_PTR_W'(wr_sum);
        end
    end

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            if (!full) begin
                n_count = r_count + RX_CNT_W'(1);
            end
        end else if (i_cmd.pop && (r_count != '0)) begin
            n_count = r_count - RX_CNT_W'(1);
            if (r_rd_ptr == RX_PTR_W'(RX_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + RX_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // head read every cycle, so a pop sees the head in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[wr_addr] <= i_cmd.data;
        end
        r_rd_data <= mem[r_rd_ptr];
    end

    assign o_count   = r_count;
    assign o_rd_data = r_rd_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RX_CNT_W'(RX_DEPTH))
        else $error("rx fill count above depth");

    a_full_push_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && i_cmd.push && !i_cmd.clear) |=> (r_count == RX_CNT_W'(RX_DEPTH)))
        else $error("overflow push changed fill count");

    a_empty_pop_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && i_cmd.pop && !i_cmd.push && !i_cmd.clear) |=> $stable(r_rd_ptr))
        else $error("pop of empty fifo moved read pointer");

endmodule

FILE: hdl/spfc_res_queue.sv
// spfc_res_queue: small result queue between the core stage and the output channel
// depends on spfc_pkg (t_out, queue sizing)
module spfc_res_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  spfc_pkg::t_out                i_data,
    input  logic                          i_pop,
    output logic                          o_valid,
    output spfc_pkg::t_out                o_data,
    output logic [spfc_pkg::RQ_CNT_W-1:0] o_count
);
    import spfc_pkg::*;

    t_out                r_slot [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_rd_ptr;
    logic [RQ_PTR_W-1:0] r_wr_ptr;
    logic [RQ_CNT_W-1:0] r_count;
    logic                do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + RQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + RQ_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + RQ_CNT_W'(1);
                2'b01:   r_count <= r_count - RQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == RQ_CNT_W'(RQ_DEPTH))))
        else $error("result queue pushed while full");

endmodule

FILE: hdl/serial_port_rx_fifo_controller_core.sv
// serial_port_rx_fifo_controller_core: top level, request decode, transfer timer, irq and control
// depends on spfc_pkg, spfc_rx_fifo, spfc_res_queue
//
//  channel   signals                             dir   payload
//  in        i_in_valid / o_in_ready             in    spfc_pkg::t_in (request, wdata, response)
//  out       o_out_valid / i_out_ready           out   spfc_pkg::t_out (rdata, status, irq, ...)
//  cfg       i_cfg_we / i_cfg_idx / i_cfg_wdata  in    register index and 16-bit data, no wait
//
// one request per cycle while input ready is high; each result is registered in the result
// stage after its state update, then passes through the output queue
// the four-entry result queue keeps input transfers flowing while the output stalls;
// input ready drops only when queued plus in-flight results would fill it
// synchronous active-low reset clears port state, control word and config to defaults
// the rx store has no reset, entries are read only below the fill count
module serial_port_rx_fifo_controller_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  spfc_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output spfc_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [15:0]     i_cfg_wdata
);
    import spfc_pkg::*;

    // per-item results held between the state update and the queue
    typedef struct packed {
        logic is_read;
        logic underflow;
        logic preset;
        logic slot;
        logic done;
    } t_stage;

    // configuration registers
    logic [1:0]  r_factor, n_factor;
    logic [1:0]  r_len, n_len;
    logic [15:0] r_reload, n_reload;

    // port state
    logic [24:0] r_countdown, n_countdown;
    logic        r_busy, n_busy;
    logic [15:0] r_cw, n_cw;
    logic        r_irq, n_irq;

    // result stage
    logic        r_res_valid;
    t_stage      r_res, n_res;

    logic                accept;
    t_fifo_cmd           fifo_cmd;
    logic [RX_CNT_W-1:0] rx_count;
    logic [7:0]          rx_rd_data;
    logic                rx_full;
    logic [LVL_W-1:0]    rx_count_inc;
    logic [RQ_CNT_W-1:0] q_count;
    logic [RQ_CNT_W:0]   q_occ;
    logic [3:0]          word_len;
    logic [19:0]         base_prod;
    logic [24:0]         duration;
    logic [15:0]         new_cw;
    t_out                res_out;

    // input ready counts results still in the stage register
    assign q_occ      = {1'b0, q_count} + {{RQ_CNT_W{1'b0}}, r_res_valid};
    assign o_in_ready = (q_occ < (RQ_CNT_W + 1)'(RQ_DEPTH));
    assign accept     = i_in_valid && o_in_ready;

    assign rx_full      = (rx_count == RX_CNT_W'(RX_DEPTH));
    assign rx_count_inc = LVL_W'(rx_count) + LVL_W'(1);

    // transfer length: reload * word length, then factor as a shift (fits 25 bits)
    assign word_len  = 4'd5 + {2'b00, r_len};
    assign base_prod = 20'(r_reload) * 20'(word_len);
    assign duration  = 25'(base_prod) << factor_shift(r_factor);

    always_comb begin
        n_factor    = r_factor;
        n_len       = r_len;
        n_reload    = r_reload;
        n_countdown = r_countdown;
        n_busy      = r_busy;
        n_cw        = r_cw;
        n_irq       = r_irq;
        fifo_cmd    = '0;
        new_cw      = i_in_data.wdata;
        n_res       = '0;
        n_res.slot  = r_cw[CW_SLOT];

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAUD_FACTOR: n_factor = i_cfg_wdata[1:0];
                CFG_CHAR_LEN:    n_len    = i_cfg_wdata[1:0];
                CFG_BAUD_RELOAD: n_reload = i_cfg_wdata;
                default:         ;
            endcase
        end

        if (accept) begin
            case (i_in_data.req_type)
                REQ_TICK: begin
                    if (r_busy) begin
                        if (r_countdown <= 25'd1) begin
                            // transfer ends: store the answer, or all ones if nobody drove
                            n_countdown   = '0;
                            n_busy        = 1'b0;
                            fifo_cmd.push = 1'b1;
                            fifo_cmd.data = i_in_data.resp_valid ? i_in_data.resp_byte
                                                                 : BYTE_NONE;
                            n_res.done    = 1'b1;
                            if (!rx_full && r_cw[CW_RXIE] &&
                                (rx_count_inc == irq_level(r_cw[CW_LVL_L +: 2]))) begin
                                n_irq = 1'b1;
                            end
                        end else begin
                            n_countdown = r_countdown - 25'd1;
                        end
                    end
                end
                REQ_DWRITE: begin
                    // with transmit enabled, restarts any running transfer
                    if (r_cw[CW_TXEN]) begin
                        n_countdown = duration;
                        n_busy      = 1'b1;
                    end
                end
                REQ_DREAD: begin
                    fifo_cmd.pop    = 1'b1;
                    n_res.is_read   = 1'b1;
                    n_res.underflow = (rx_count == '0);
                end
                REQ_CWRITE: begin
                    if (new_cw[CW_ACK]) begin
                        n_irq = 1'b0;
                    end
                    if (new_cw[CW_SRST]) begin
                        // soft reset: empty fifo, cancel transfer, clear irq, defaults for config
                        fifo_cmd.clear  = 1'b1;
                        n_countdown     = '0;
                        n_busy          = 1'b0;
                        n_irq           = 1'b0;
                        n_factor        = FACTOR_RST;
                        n_len           = LEN_RST;
                        n_reload        = RELOAD_RST;
                        new_cw[CW_SRST] = 1'b0;
                    end
                    // dtr edge judged against the old word; the old slot is the one reset
                    n_res.preset = !r_cw[CW_DTR] && new_cw[CW_DTR];
                    n_cw         = new_cw;
                    if (!n_res.preset) begin
                        n_res.slot = new_cw[CW_SLOT];
                    end
                end
                REQ_STATUS: ;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor    <= FACTOR_RST;
            r_len       <= LEN_RST;
            r_reload    <= RELOAD_RST;
            r_countdown <= '0;
            r_busy      <= 1'b0;
            r_cw        <= '0;
            r_irq       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_factor    <= n_factor;
            r_len       <= n_len;
            r_reload    <= n_reload;
            r_countdown <= n_countdown;
            r_busy      <= n_busy;
            r_cw        <= n_cw;
            r_irq       <= n_irq;
            r_res_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    spfc_rx_fifo u_rx_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (fifo_cmd),
        .o_count   (rx_count),
        .o_rd_data (rx_rd_data)
    );

    // state registers now hold the post-item values, so status comes straight from them
    always_comb begin
        if (r_res.is_read) begin
            res_out.rdata = r_res.underflow ? BYTE_NONE : rx_rd_data;
        end else begin
            res_out.rdata = 8'h00;
        end
        res_out.status       = {r_irq, 5'b00000, 1'b0, !r_busy, (rx_count != '0), 1'b1};
        res_out.irq_line     = r_irq;
        res_out.periph_reset = r_res.preset;
        res_out.slot_sel     = r_res.slot;
        res_out.xfer_done    = r_res.done;
    end

    spfc_res_queue u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_res_valid),
        .i_data  (res_out),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_count (q_count)
    );

    a_idle_timer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_countdown == '0))
        else $error("transfer timer nonzero while idle");

    a_done_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_res.done) |=> (!r_busy && r_res_valid))
        else $error("completed transfer left port busy");

    a_irq_rise_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq) |-> $past(fifo_cmd.push))
        else $error("irq raised without an rx push");

    a_preset_on_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_res.preset) |=> r_cw[CW_DTR])
        else $error("peripheral reset without dtr set");

endmodule

FILE: verif/spfc_scoreboard_pkg.sv
`timescale 1ns / 100ps
// scoreboard for the serial port rx fifo controller: tracks port state, predicts each result
// depends on spfc_pkg for the request and result structs, codes and bit positions
package spfc_scoreboard_pkg;
    import spfc_pkg::*;

    class rx_port_scoreboard;
        // configuration copy
        bit [1:0]  factor_sel;
        bit [1:0]  len_sel;
        bit [15:0] reload;
        // port state copy
        bit [15:0] ctrl;
        bit [7:0]  rx_bytes[$];
        bit [24:0] countdown;
        bit        busy;
        bit        irq;
        // results still owed by the block, oldest first
        t_out      pending_results[$];
        int        mismatches;

        function new();
            ctrl = '0;
            mismatches = 0;
            soft_clear();
        endfunction

        // state cleared by reset and by the soft reset bit
        function void soft_clear();
            rx_bytes.delete();
            countdown = '0;
            busy = 1'b0;
            irq = 1'b0;
            factor_sel = FACTOR_RST;
            len_sel = LEN_RST;
            reload = RELOAD_RST;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] val);
            case (idx)
                CFG_BAUD_FACTOR: factor_sel = val[1:0];
                CFG_CHAR_LEN:    len_sel = val[1:0];
                CFG_BAUD_RELOAD: reload = val;
                default: ;
            endcase
        endfunction

        // reload x factor x word length, truncated to the countdown width
        function bit [24:0] transfer_ticks();
            int unsigned mult;
            int unsigned prod;
            case (factor_sel)
                2'd2:    mult = 16;
                2'd3:    mult = 64;
                default: mult = 1;
            endcase
            prod = int'(reload) * mult * (5 + int'(len_sel));
            return prod[24:0];
        endfunction

        function int fill_level();
            case (ctrl[CW_LVL_L +: 2])
                2'd0:    return 1;
                2'd1:    return 2;
                2'd2:    return 4;
                default: return 8;
            endcase
        endfunction

        function void push_byte(input bit [7:0] b);
            if (rx_bytes.size() >= RX_DEPTH) begin
                // full: overwrite the newest entry, no count change, no irq
                rx_bytes[RX_DEPTH-1] = b;
            end else begin
                rx_bytes.push_back(b);
                if (ctrl[CW_RXIE] && rx_bytes.size() == fill_level())
                    irq = 1'b1;
            end
        endfunction

        function void note_request(input t_in r);
            t_out       e;
            bit [15:0]  nw;
            e = '0;
            e.slot_sel = ctrl[CW_SLOT];
            case (r.req_type)
                REQ_TICK: begin
                    if (busy) begin
                        if (countdown <= 1) begin
                            countdown = '0;
                            busy = 1'b0;
                            push_byte(r.resp_valid ? r.resp_byte : BYTE_NONE);
                            e.xfer_done = 1'b1;
                        end else begin
                            countdown = countdown - 25'd1;
                        end
                    end
                end
                REQ_DWRITE: begin
                    if (ctrl[CW_TXEN]) begin
                        countdown = transfer_ticks();
                        busy = 1'b1;
                    end
                end
                REQ_DREAD: begin
                    if (rx_bytes.size() == 0)
                        e.rdata = BYTE_NONE;
                    else
                        e.rdata = rx_bytes.pop_front();
                end
                REQ_CWRITE: begin
                    nw = r.wdata;
                    if (nw[CW_ACK])
                        irq = 1'b0;
                    if (nw[CW_SRST]) begin
                        soft_clear();
                        nw[CW_SRST] = 1'b0;
                    end
                    // dtr edge judged against the old control word
                    if (!ctrl[CW_DTR] && nw[CW_DTR])
                        e.periph_reset = 1'b1;
                    ctrl = nw;
                    if (!e.periph_reset)
                        e.slot_sel = ctrl[CW_SLOT];
                end
                default: ;
            endcase
            e.status = {irq, 6'b0, !busy, rx_bytes.size() != 0, 1'b1};
            e.irq_line = irq;
            pending_results.push_back(e);
        endfunction

        function void compare_field(input string name, input logic [9:0] want,
                                    input logic [9:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        endfunction

        function void check_result(input t_out got);
            t_out e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h with nothing pending", got);
                return;
            end
            e = pending_results.pop_front();
            compare_field("rdata", 10'(e.rdata), 10'(got.rdata));
            compare_field("status", e.status, got.status);
            compare_field("irq_line", 10'(e.irq_line), 10'(got.irq_line));
            compare_field("periph_reset", 10'(e.periph_reset), 10'(got.periph_reset));
            compare_field("slot_sel", 10'(e.slot_sel), 10'(got.slot_sel));
            compare_field("xfer_done", 10'(e.xfer_done), 10'(got.xfer_done));
        endfunction
    endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives requests, config writes and output stalls into the rx fifo controller core
// depends on spfc_pkg, spfc_scoreboard_pkg and the serial_port_rx_fifo_controller_core rtl
module tb_top;
    import spfc_pkg::*;
    import spfc_scoreboard_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int TARGET_ITEMS = 1450;
    localparam int PHASE_ITEMS  = 90;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [15:0] cfg_wdata = '0;

    rx_port_scoreboard sb;
    bit  steady = 1'b0;   // no idling on either side while set
    int  sent = 0;
    int  quiet = 0;

    serial_port_rx_fifo_controller_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side stalls at random, changes on the falling edge
    always @(negedge i_clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 38);
    end

    // every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // all fields random, request code given
    function automatic t_in make_req(input logic [2:0] kind);
        t_in r;
        r.req_type = kind;
        r.wdata = 16'($urandom);
        r.resp_byte = 8'($urandom);
        r.resp_valid = ($urandom_range(0, 4) != 0);
        return r;
    endfunction

    // control word: tx mostly enabled, soft reset rare, rest random
    function automatic logic [15:0] random_ctrl();
        logic [15:0] w;
        w = 16'($urandom);
        w[CW_SRST] = ($urandom_range(0, 24) == 0);
        w[CW_TXEN] = ($urandom_range(0, 9) != 0);
        w[CW_RXIE] = ($urandom_range(0, 9) < 7);
        return w;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send(input t_in r);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 38) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        sb.note_request(r);
        sent++;
    endtask

    task automatic send_fields(input logic [2:0] kind, input logic [15:0] w,
                               input logic [7:0] resp, input logic resp_ok);
        t_in r;
        r.req_type = kind;
        r.wdata = w;
        r.resp_byte = resp;
        r.resp_valid = resp_ok;
        send(r);
    endtask

    // stop sending and wait until every owed result has arrived
    task automatic drain(input int extra);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // all three registers, written only after every owed result has drained
    task automatic set_port(input logic [1:0] fsel, input logic [1:0] lsel,
                            input logic [15:0] rld);
        drain(4);
        // unused upper bits carry noise, the block keeps the low two
        cfg_write(CFG_BAUD_FACTOR, {14'($urandom), fsel});
        cfg_write(CFG_CHAR_LEN, {14'($urandom), lsel});
        cfg_write(CFG_BAUD_RELOAD, rld);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int n_items, input int read_w);
        int          start_cnt;
        int          pick;
        int          nt;
        logic [2:0]  kind;
        t_in         r;
        start_cnt = sent;
        while (sent - start_cnt < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // data write followed by enough ticks to finish the byte, mostly
                send(make_req(REQ_DWRITE));
                if (sb.busy) begin
                    nt = (sb.countdown <= 1) ? 1 : int'(sb.countdown);
                    if (nt > 130)
                        nt = $urandom_range(1, 48);
                    else if ($urandom_range(0, 9) == 0)
                        nt = $urandom_range(1, nt);   // cut short, next write cancels
                    else
                        nt += $urandom_range(0, 2);
                    repeat (nt) begin
                        if ($urandom_range(0, 99) < 6)
                            send(make_req($urandom_range(0, 1) ? REQ_STATUS : REQ_DREAD));
                        send(make_req(REQ_TICK));
                    end
                end
            end else if (pick < 50 + read_w) begin
                repeat ($urandom_range(1, 5)) send(make_req(REQ_DREAD));
            end else if (pick < 62 + read_w) begin
                r = make_req(REQ_CWRITE);
                r.wdata = random_ctrl();
                send(r);
            end else begin
                // anything, unknown codes included
                kind = 3'($urandom_range(0, 7));
                r = make_req(kind);
                if (kind == REQ_CWRITE)
                    r.wdata = random_ctrl();
                send(r);
            end
        end
    endtask

    initial begin
        int          phase;
        logic [1:0]  fsel;
        logic [1:0]  lsel;
        logic [15:0] rld;
        sb = new();

        // synchronous reset, released on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length transfers for the directed part
        set_port(2'd0, 2'd0, 16'd0);

        send_fields(REQ_STATUS, 16'h0000, 8'h00, 1'b0);
        send_fields(REQ_DREAD, 16'hFFFF, 8'hFF, 1'b1);     // read of an empty fifo
        send_fields(REQ_DWRITE, 16'hFFFF, 8'hFF, 1'b1);    // transmit disabled, ignored
        send_fields(REQ_TICK, 16'h0000, 8'h00, 1'b1);      // tick while idle
        send_fields(3'd7, 16'hFFFF, 8'hFF, 1'b1);          // unknown request
        // txen, dtr rising, rx irq at one byte, slot two
        send_fields(REQ_CWRITE, 16'h2803, 8'h00, 1'b0);
        send_fields(REQ_DWRITE, 16'h00A5, 8'h00, 1'b0);
        send_fields(REQ_TICK, 16'h0000, 8'h3C, 1'b0);      // no device, 0xff goes in
        send_fields(REQ_DWRITE, 16'h005A, 8'h00, 1'b0);
        send_fields(REQ_DWRITE, 16'h00FF, 8'h00, 1'b0);    // restart over a running one
        send_fields(REQ_TICK, 16'h0000, 8'h00, 1'b1);
        send_fields(REQ_DREAD, 16'h0000, 8'h00, 1'b0);
        send_fields(REQ_DREAD, 16'h0000, 8'h00, 1'b0);
        send_fields(REQ_CWRITE, 16'h0011, 8'h00, 1'b0);    // ack, dtr falls
        send_fields(REQ_CWRITE, 16'hFFFF, 8'hFF, 1'b1);    // soft reset with dtr rising
        send_fields(REQ_DWRITE, 16'h0000, 8'h00, 1'b0);    // default timing, long transfer
        send_fields(REQ_TICK, 16'hFFFF, 8'hFF, 1'b1);
        send_fields(REQ_STATUS, 16'hFFFF, 8'hFF, 1'b1);
        send_fields(3'd5, 16'h0000, 8'h00, 1'b0);
        send_fields(REQ_CWRITE, 16'h0000, 8'h00, 1'b0);

        // fixed extremes first, then random timing
        phase = 0;
        while (sent < TARGET_ITEMS) begin
            case (phase)
                0: begin fsel = 2'd3; lsel = 2'd3; rld = 16'hFFFF; end
                1: begin fsel = 2'd0; lsel = 2'd3; rld = 16'd1; end
                2: begin fsel = 2'd2; lsel = 2'd0; rld = 16'd0; end
                3: begin fsel = 2'd1; lsel = 2'd1; rld = 16'd2; end
                default: begin
                    fsel = 2'($urandom_range(0, 3));
                    lsel = 2'($urandom_range(0, 3));
                    if (fsel >= 2'd2)
                        rld = ($urandom_range(0, 3) == 0) ? 16'd1 : 16'd0;
                    else
                        rld = 16'($urandom_range(0, 5));
                end
            endcase
            set_port(fsel, lsel, rld);
            steady = (phase == 3 || phase == 7);
            random_phase(PHASE_ITEMS, $urandom_range(3, 25));
            steady = 1'b0;
            phase++;
        end

        drain(10);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
